### rtl/sample_min_max_mean_rate_tracker_defines.svh
// Assertion macros used by the statistics tracker top level.
`ifndef SAMPLE_MIN_MAX_MEAN_RATE_TRACKER_DEFINES_SVH
`define SAMPLE_MIN_MAX_MEAN_RATE_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/smmt_pkg.sv
// Shared types and constants for the statistics tracker.
package smmt_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = 32;
  localparam int REQ_W      = 3;
  localparam int OUT_W      = 80;
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);
  localparam int RATE_SCALE = 1000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = 16'hFFFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 3'd0,
    REQ_EVENT  = 3'd1,
    REQ_TICK   = 3'd2,
    REQ_REPORT = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  typedef struct packed {
    logic sample;
    logic rate_evt;
    logic ms_tick;
    logic clear;
    logic rate_start;
    logic rate_save;
    logic mean_start;
    logic div_step;
    logic out_load;
  } cmd_t;

endpackage

### rtl/smmt_ctrl.sv
// Controller: request decode, divider sequencing and output handshake.
module smmt_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_valid,
  input  logic [smmt_pkg::REQ_W-1:0]        s_kind,
  output logic                              s_ready,
  output logic                              m_valid,
  input  logic                              m_ready,
  output smmt_pkg::cmd_t                    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_RATE      = 5'b00010,
    ST_MEAN_LOAD = 5'b00100,
    ST_MEAN      = 5'b01000,
    ST_FINISH    = 5'b10000
  } state_t;

  localparam logic [smmt_pkg::STEP_CNT_W-1:0] STEP_LAST =
    smmt_pkg::STEP_CNT_W'(smmt_pkg::DIV_STEPS - 1);

  state_t                              state, state_next;
  logic [smmt_pkg::STEP_CNT_W-1:0]     step_cnt, step_cnt_next;
  logic                                out_valid, out_valid_next;
  logic                                take;

  assign s_ready = (state == ST_IDLE);
  assign take    = s_valid && s_ready;
  assign m_valid = out_valid;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    step_cnt_next  = step_cnt;
    out_valid_next = out_valid && !m_ready;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (s_kind)
            smmt_pkg::REQ_SAMPLE: cmd.sample   = 1'b1;
            smmt_pkg::REQ_EVENT:  cmd.rate_evt = 1'b1;
            smmt_pkg::REQ_TICK:   cmd.ms_tick  = 1'b1;
            smmt_pkg::REQ_CLEAR:  cmd.clear    = 1'b1;
            smmt_pkg::REQ_REPORT: begin
              cmd.rate_start = 1'b1;
              step_cnt_next  = '0;
              state_next     = ST_RATE;
            end
            default: ;
          endcase
        end
      end
      ST_RATE: begin
        cmd.div_step = 1'b1;
        if (step_cnt == STEP_LAST) begin
          state_next = ST_MEAN_LOAD;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_MEAN_LOAD: begin
        cmd.rate_save  = 1'b1;
        cmd.mean_start = 1'b1;
        step_cnt_next  = '0;
        state_next     = ST_MEAN;
      end
      ST_MEAN: begin
        cmd.div_step = 1'b1;
        if (step_cnt == STEP_LAST) begin
          state_next = ST_FINISH;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (!out_valid || m_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/smmt_dp.sv
// Datapath: statistics registers, shared restoring divider, output register.
module smmt_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  smmt_pkg::cmd_t                     cmd,
  input  logic [smmt_pkg::SAMPLE_W-1:0]      sample_value,
  output logic [smmt_pkg::OUT_W-1:0]         result
);

  localparam int SW = smmt_pkg::SAMPLE_W;
  localparam int QW = smmt_pkg::SUM_W;
  localparam int CW = smmt_pkg::CNT_W;
  localparam int PW = CW + 10;

  logic [SW-1:0] max_seen, min_seen;
  logic [QW-1:0] sample_sum;
  logic [CW-1:0] sample_total, event_total, elapsed_ms;
  logic [QW:0]   sum_add;
  logic [PW-1:0] event_scaled;

  logic [QW-1:0] quo;
  logic [CW-1:0] rem, divisor;
  logic [CW:0]   rem_shift;
  logic [CW+1:0] trial;
  logic [CW-1:0] rate_res;
  logic [SW-1:0] mean_res;

  assign sum_add      = {1'b0, sample_sum} + (QW+1)'(sample_value);
  assign event_scaled = PW'(event_total) * PW'(smmt_pkg::RATE_SCALE);

  // statistics registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      max_seen     <= '0;
      min_seen     <= smmt_pkg::SAMPLE_TOP;
      sample_sum   <= '0;
      sample_total <= '0;
      event_total  <= '0;
      elapsed_ms   <= '0;
    end else begin
      if (cmd.sample) begin
        if (sample_value > max_seen) max_seen <= sample_value;
        if (sample_value < min_seen) min_seen <= sample_value;
        sample_sum <= sum_add[QW] ? '1 : sum_add[QW-1:0];
        if (!(&sample_total)) sample_total <= sample_total + 1'b1;
      end
      if (cmd.rate_evt && !(&event_total)) event_total <= event_total + 1'b1;
      if (cmd.ms_tick && !(&elapsed_ms)) elapsed_ms <= elapsed_ms + 1'b1;
    end
  end

  // one quotient bit per step
  assign rem_shift = {rem, quo[QW-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (cmd.rate_start) begin
      quo     <= QW'(event_scaled);
      rem     <= '0;
      divisor <= elapsed_ms;
    end else if (cmd.mean_start) begin
      quo     <= sample_sum;
      rem     <= '0;
      divisor <= sample_total;
    end else if (cmd.div_step) begin
      if (!trial[CW+1]) begin
        rem <= trial[CW-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= rem_shift[CW-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (divisor == '0) begin
      mean_res = '0;
    end else if (|quo[QW-1:SW]) begin
      mean_res = smmt_pkg::SAMPLE_TOP;
    end else begin
      mean_res = quo[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rate_save) begin
      if (divisor == '0) begin
        rate_res <= '0;
      end else if (|quo[QW-1:CW]) begin
        rate_res <= '1;
      end else begin
        rate_res <= quo[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= {min_seen, max_seen, mean_res, rate_res};
    end
  end

endmodule

### rtl/sample_min_max_mean_rate_tracker.sv
// Top level of the running sample statistics and event-rate tracker.
//
//  channel   dir  tdata (low bit up)                         tuser
//  s_axis    in   sample_value[15:0]                          req_type[2:0]
//  m_axis    out  rate_hz[31:0] mean_value[47:32]             -
//                 max_value[63:48] min_value[79:64]
//
// Sample, event, tick and clear requests are taken back to back while idle.
// A report runs the shared one-bit-per-cycle divider twice (48 steps each),
// first for the rate, then for the mean; s_axis_tready stays low throughout.
// A finished result waits in the output register while requests flow again;
// a later report holds in its last cycle, input stalled, until it frees up.
// rst is synchronous and active high; it clears all statistics.
`include "sample_min_max_mean_rate_tracker_defines.svh"

module sample_min_max_mean_rate_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // sample_value[15:0]
  input  logic [smmt_pkg::REQ_W-1:0]     s_axis_tuser,  // req_type[2:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rate_hz[31:0], mean_value[47:32], max_value[63:48], min_value[79:64]
  output logic [smmt_pkg::OUT_W-1:0]     m_axis_tdata
);

  smmt_pkg::cmd_t cmd;

  smmt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_kind  (s_axis_tuser),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd)
  );

  smmt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample_value (s_axis_tdata),
    .result       (m_axis_tdata)
  );

  `SMMT_ASSERT_NEXT(a_report_stalls, s_axis_tvalid && s_axis_tready && s_axis_tuser == smmt_pkg::REQ_REPORT, !s_axis_tready, "report request did not stall input")
  `SMMT_ASSERT_IMPL(a_no_take_while_div, cmd.div_step, !s_axis_tready, "input open during division")
  `SMMT_ASSERT_IMPL(a_single_update, 1'b1, $onehot0({cmd.sample, cmd.rate_evt, cmd.ms_tick, cmd.clear, cmd.rate_start}), "more than one update command")
  `SMMT_ASSERT_NEXT(a_load_shows, cmd.out_load, m_axis_tvalid, "loaded result not presented")

endmodule
